// File: design/elx_pkg.sv
// Shared types and constants for the expression number/operator lexer.
`default_nettype none
package elx_pkg;

  localparam int MANT_BITS = 32;
  localparam int ACC_XW    = MANT_BITS + 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  localparam logic [15:0] LINE_ONE = 16'd1;
  localparam logic [3:0]  FRAC_MAX = 4'd15;
  localparam logic [3:0]  FRAC_ONE = 4'd1;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef enum logic [2:0] {
    CL_DIGIT,
    CL_POINT,
    CL_BLANK,
    CL_NEWLINE,
    CL_OP,
    CL_OTHER,
    CL_END
  } char_class_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_INT   = 4'b0010,
    PH_POINT = 4'b0100,
    PH_FRAC  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    TK_OP  = 2'd0,
    TK_NUM = 2'd1,
    TK_ERR = 2'd2,
    TK_END = 2'd3
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYMBOL = 2'd1,
    ERR_POINT  = 2'd2
  } err_kind_e;

  typedef struct packed {
    char_class_e cls;
    logic [7:0]  ch;
  } lex_item_t;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  op_char;
    logic [31:0] mant;
    logic [3:0]  frac;
    logic        sat;
    logic [15:0] line;
    err_kind_e   err;
    logic        last;
  } token_t;

endpackage
`default_nettype wire

// File: design/elx_front.sv
// Input side: accepts characters and classifies them into queue items.
`default_nettype none
module elx_front (
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,  // char_code
  input  wire logic              s_axis_tuser,  // end_of_input
  input  wire logic              full_i,
  output logic                   push_o,
  output elx_pkg::lex_item_t     item_o
);
  import elx_pkg::*;

  char_class_e cls;

  always_comb begin
    if (s_axis_tuser) begin
      cls = CL_END;
    end else if (s_axis_tdata inside {[CH_ZERO:CH_NINE]}) begin
      cls = CL_DIGIT;
    end else if (s_axis_tdata == CH_POINT) begin
      cls = CL_POINT;
    end else if (s_axis_tdata == CH_NL) begin
      cls = CL_NEWLINE;
    end else if (s_axis_tdata inside {CH_SPACE, CH_TAB}) begin
      cls = CL_BLANK;
    end else if (s_axis_tdata inside {CH_PLUS, CH_MINUS, CH_STAR, CH_EQUAL,
                                      CH_SLASH, CH_LPAREN, CH_RPAREN}) begin
      cls = CL_OP;
    end else begin
      cls = CL_OTHER;
    end
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign item_o.cls    = cls;
  assign item_o.ch     = s_axis_tdata;

endmodule
`default_nettype wire

// File: design/elx_fifo.sv
// Short queue of classified items between front and back.
`default_nettype none
module elx_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire elx_pkg::lex_item_t item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output elx_pkg::lex_item_t      head_o
);
  import elx_pkg::*;

  lex_item_t          mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? Q_PTR_W'((Q_CNT_W'(wr_q) + 1'b1) % Q_CNT_W'(Q_DEPTH)) : wr_q;
    rd_d  = do_pop  ? Q_PTR_W'((Q_CNT_W'(rd_q) + 1'b1) % Q_CNT_W'(Q_DEPTH)) : rd_q;
    cnt_d = cnt_q + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// File: design/elx_back.sv
// Back end: lexer state, token forming and output staging.
`default_nettype none
module elx_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire elx_pkg::lex_item_t head_i,
  output logic                    pop_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [63:0]             m_axis_tdata,  // operator_char, number_mantissa,
                                                 // fraction_digits, mantissa_saturated,
                                                 // line_index, error_kind, zero pad
  output logic [1:0]              m_axis_tuser,  // token_kind
  output logic                    m_axis_tlast   // last_of_item
);
  import elx_pkg::*;

  phase_e               phase_q, phase_d;
  logic [MANT_BITS-1:0] acc_q, acc_d;
  logic [3:0]           frac_q, frac_d;
  logic                 ovf_q, ovf_d;
  logic [15:0]          line_q, line_d;

  token_t               out_q, pend_q;
  logic                 out_v_q, pend_v_q;

  token_t               tok0, tok1, base_tok, num_tok, idle_tok;
  logic [1:0]           ntok;
  logic                 idle_has;
  logic [ACC_XW-1:0]    acc_x, acc_w;
  logic                 add_ovf;
  logic [MANT_BITS-1:0] add_val;
  logic [15:0]          line_inc;
  logic                 free, room, is_digit;

  assign is_digit = (head_i.cls == CL_DIGIT);
  assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + 16'd1;

  // acc * 10 + digit, saturating
  always_comb begin
    acc_x   = ACC_XW'(acc_q);
    acc_w   = (acc_x << 3) + (acc_x << 1) + ACC_XW'(head_i.ch[3:0]);
    add_ovf = |acc_w[ACC_XW-1:MANT_BITS];
    add_val = add_ovf ? '1 : acc_w[MANT_BITS-1:0];
  end

  always_comb begin
    base_tok      = '0;
    base_tok.line = line_q;

    num_tok       = base_tok;
    num_tok.kind  = TK_NUM;
    num_tok.mant  = 32'(acc_q);
    num_tok.frac  = frac_q;
    num_tok.sat   = ovf_q;

    idle_tok = base_tok;
    idle_has = 1'b0;
    if (head_i.cls == CL_OP) begin
      idle_tok.kind    = TK_OP;
      idle_tok.op_char = head_i.ch;
      idle_has         = 1'b1;
    end else if (head_i.cls == CL_OTHER || head_i.cls == CL_POINT) begin
      idle_tok.kind = TK_ERR;
      idle_tok.err  = ERR_SYMBOL;
      idle_has      = 1'b1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    ovf_d   = ovf_q;
    line_d  = line_q;
    tok0    = base_tok;
    tok1    = base_tok;
    ntok    = 2'd0;

    if (head_i.cls == CL_END) begin
      phase_d = PH_IDLE;
      acc_d   = '0;
      frac_d  = '0;
      ovf_d   = 1'b0;
      tok1.kind = TK_END;
      case (phase_q)
        PH_INT, PH_FRAC: begin
          tok0 = num_tok;
          ntok = 2'd2;
        end
        PH_POINT: begin
          tok0.kind = TK_ERR;
          tok0.err  = ERR_POINT;
          ntok      = 2'd2;
        end
        default: begin
          tok0.kind = TK_END;
          ntok      = 2'd1;
        end
      endcase
    end else begin
      case (phase_q)
        PH_INT, PH_FRAC: begin
          if (is_digit) begin
            acc_d = add_val;
            ovf_d = ovf_q | add_ovf;
            if (phase_q == PH_FRAC) begin
              if (frac_q < FRAC_MAX) begin
                frac_d = frac_q + 4'd1;
              end else begin
                ovf_d = 1'b1;
              end
            end
          end else if (head_i.cls == CL_POINT && phase_q == PH_INT) begin
            phase_d = PH_POINT;
          end else begin
            phase_d = PH_IDLE;
            acc_d   = '0;
            frac_d  = '0;
            ovf_d   = 1'b0;
            tok0    = num_tok;
            tok1    = idle_tok;
            ntok    = idle_has ? 2'd2 : 2'd1;
            if (head_i.cls == CL_NEWLINE) begin
              line_d = line_inc;
            end
          end
        end
        PH_POINT: begin
          if (is_digit) begin
            phase_d = PH_FRAC;
            acc_d   = add_val;
            ovf_d   = ovf_q | add_ovf;
            frac_d  = FRAC_ONE;
          end else begin
            phase_d   = PH_IDLE;
            acc_d     = '0;
            frac_d    = '0;
            ovf_d     = 1'b0;
            tok0.kind = TK_ERR;
            tok0.err  = ERR_POINT;
            ntok      = 2'd1;
          end
        end
        default: begin
          if (is_digit) begin
            phase_d = PH_INT;
            acc_d   = MANT_BITS'(head_i.ch[3:0]);
            frac_d  = '0;
            ovf_d   = 1'b0;
          end else if (head_i.cls == CL_NEWLINE) begin
            line_d = line_inc;
          end else begin
            tok0 = idle_tok;
            ntok = idle_has ? 2'd1 : 2'd0;
          end
        end
      endcase
    end

    if (ntok == 2'd2) begin
      tok1.last = 1'b1;
    end else begin
      tok0.last = 1'b1;
    end
  end

  assign free  = !out_v_q || m_axis_tready;
  assign room  = !pend_v_q && free;
  assign pop_o = head_valid_i && (ntok == 2'd0 || room);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      acc_q    <= '0;
      frac_q   <= '0;
      ovf_q    <= 1'b0;
      line_q   <= LINE_ONE;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        frac_q  <= frac_d;
        ovf_q   <= ovf_d;
        line_q  <= line_d;
      end
      if (pend_v_q && free) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end else if (pop_o && ntok != 2'd0) begin
        out_v_q  <= 1'b1;
        pend_v_q <= (ntok == 2'd2);
      end else if (free) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_v_q && free) begin
      out_q <= pend_q;
    end else if (pop_o && ntok != 2'd0) begin
      out_q  <= tok0;
      pend_q <= tok1;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {1'b0, out_q.err, out_q.line, out_q.sat, out_q.frac,
                          out_q.mant, out_q.op_char};

`ifndef SYNTH
  a_pend_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> out_v_q) else $error("pending token without output token");

  a_no_pop_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_v_q && !m_axis_tready) |=> pend_v_q && $stable(pend_q))
    else $error("pending token lost");

  a_frac_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FRAC) == (frac_q != '0))
    else $error("fraction count out of step with phase");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0) else $error("line counter reached zero");
`endif

endmodule
`default_nettype wire

// File: design/expression_number_operator_lexer.sv
// Top level of the expression number/operator lexer.
// Usage:
//   s_axis carries one item per character: tdata is the ASCII code, tuser set
//   marks end of text (tdata then ignored). m_axis carries tokens: tuser is
//   the token kind, tlast marks the final token caused by one input item.
//   An input item gives zero, one or two tokens (a number is emitted when the
//   character after it arrives, then that character is handled).
// Token path: an accepted item is written into the queue, popped by the back
//   end, and its first token is registered in the output register for m_axis.
// Throughput: one item per cycle while each item gives at most one token and
//   m_axis is ready; after an item giving two tokens, items that give tokens
//   wait until the pending second token has moved to the single output port.
// Front end classifies into a four-item queue; the back end holds lexer
// state and an output register plus one pending token slot.
// Reset: lexer idle, line counter 1, queue and output empty.
// A stall on m_axis fills the queue; s_axis_tready drops when it is full,
// and items that produce no token keep draining meanwhile.
`default_nettype none
module expression_number_operator_lexer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // char_code
  input  wire logic        s_axis_tuser,  // end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // operator_char, number_mantissa,
                                          // fraction_digits, mantissa_saturated,
                                          // line_index, error_kind, zero pad
  output logic [1:0]       m_axis_tuser,  // token_kind
  output logic             m_axis_tlast   // last_of_item
);
  import elx_pkg::*;

  lex_item_t in_item, head;
  logic      push, full, pop, head_valid;

  elx_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .item_o        (in_item)
  );

  elx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  elx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire
